@@ rtl/core/ntcc_pkg.sv @@
// ----------------------------------------------------------------------------
// ntcc_pkg: shared types and constants of the nested tag capacity checker
// Holds the stack geometry, the stack entry type and the shift command that
// the control logic hands to the row of stack cells.
// ----------------------------------------------------------------------------
package ntcc_pkg;

    // Stack depth and width of a level's size and inner sum.
    localparam int MAX_DEPTH = 256;
    localparam int SIZE_BITS = 23;

    // Width of a token on the input channel.
    localparam int TOKEN_W = 24;

    // Stack pointer counts 0 .. MAX_DEPTH open levels.
    localparam int SP_W = $clog2(MAX_DEPTH + 1);

    // Largest storable size; inner sums saturate here.
    localparam logic [63:0] SIZE_MAX = (64'd1 << SIZE_BITS) - 64'd1;

    typedef struct packed {
        logic [SIZE_BITS-1:0] size;
        logic [SIZE_BITS-1:0] sum;
    } t_entry;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_PUSH,
        OP_POP
    } t_op;

    typedef struct packed {
        t_op    op;
        t_entry push_entry;
        t_entry pop_entry;
    } t_stack_cmd;

    typedef struct packed {
        logic [SP_W-1:0] sp;
        logic            failed;
    } t_status;

endpackage : ntcc_pkg

@@ rtl/core/ntcc_cell.sv @@
// ----------------------------------------------------------------------------
// ntcc_cell: one stack cell
// Holds one level's size and inner sum. On a push it takes the entry from the
// cell above, on a pop the entry from the cell below, otherwise it holds.
// ----------------------------------------------------------------------------
module ntcc_cell
    import ntcc_pkg::*;
(
    input  logic   i_clk,
    input  t_op    i_op,
    input  t_entry i_above,
    input  t_entry i_below,
    output t_entry o_entry
);

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        case (i_op)
            OP_PUSH: n_entry = i_above;
            OP_POP:  n_entry = i_below;
            default: n_entry = r_entry;
        endcase
    end

    // Payload only: contents are meaningless above the stack pointer.
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule : ntcc_cell

@@ rtl/core/ntcc_ctrl.sv @@
// ----------------------------------------------------------------------------
// ntcc_ctrl: token decoder and stack control
// Keeps the stack pointer and the failure latch, checks each token against
// the top two stack entries and issues the shift command for the cell row.
// ----------------------------------------------------------------------------
module ntcc_ctrl
    import ntcc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_fire,
    input  logic signed [TOKEN_W-1:0] i_token_value,
    input  logic                      i_last_token,
    input  t_entry                    i_top,
    input  t_entry                    i_next,
    output t_stack_cmd                o_cmd,
    output t_status                   o_status,
    output logic                      o_verdict
);

    logic [SP_W-1:0]      r_sp;
    logic [SP_W-1:0]      n_sp;
    logic                 r_failed;
    logic                 n_failed;

    logic [TOKEN_W-1:0]   w_bits;
    logic [TOKEN_W-1:0]   w_mag;
    logic                 w_open;
    logic                 w_oversize;
    logic                 w_full;
    logic                 w_empty;
    logic                 w_mismatch;
    logic                 w_no_room;
    logic [SIZE_BITS:0]   w_sum;
    logic [SP_W-1:0]      w_sp_proc;
    logic                 w_failed_proc;

    assign w_bits     = unsigned'(i_token_value);
    assign w_mag      = (~w_bits) + TOKEN_W'(1);
    assign w_open     = w_bits[TOKEN_W-1];
    assign w_oversize = 64'(w_mag) > SIZE_MAX;
    assign w_full     = (r_sp == SP_W'(MAX_DEPTH));
    assign w_empty    = (r_sp == '0);
    assign w_mismatch = 64'(i_top.size) != 64'(w_bits);
    assign w_no_room  = 64'(i_top.sum) >= 64'(w_bits);

    // Parent's inner sum after the top level closes, saturating.
    assign w_sum = {1'b0, i_next.sum} + {1'b0, i_top.size};

    always_comb begin
        o_cmd.op                = OP_HOLD;
        o_cmd.push_entry.size   = SIZE_BITS'(w_mag);
        o_cmd.push_entry.sum    = '0;
        o_cmd.pop_entry.size    = i_next.size;
        o_cmd.pop_entry.sum     = w_sum[SIZE_BITS] ? {SIZE_BITS{1'b1}} : w_sum[SIZE_BITS-1:0];
        w_sp_proc               = r_sp;
        w_failed_proc           = r_failed;

        if (i_fire && !r_failed) begin
            if (w_open) begin
                if (w_full || w_oversize) begin
                    w_failed_proc = 1'b1;
                end else begin
                    o_cmd.op  = OP_PUSH;
                    w_sp_proc = r_sp + SP_W'(1);
                end
            end else begin
                if (w_empty || w_mismatch || w_no_room) begin
                    w_failed_proc = 1'b1;
                end else begin
                    o_cmd.op  = OP_POP;
                    w_sp_proc = r_sp - SP_W'(1);
                end
            end
        end

        o_verdict = !w_failed_proc && (w_sp_proc == '0);

        // The last token ends the sequence and rearms the checker.
        if (i_fire && i_last_token) begin
            n_sp     = '0;
            n_failed = 1'b0;
        end else begin
            n_sp     = w_sp_proc;
            n_failed = w_failed_proc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp     <= '0;
            r_failed <= 1'b0;
        end else begin
            r_sp     <= n_sp;
            r_failed <= n_failed;
        end
    end

    assign o_status.sp     = r_sp;
    assign o_status.failed = r_failed;

endmodule : ntcc_ctrl

@@ rtl/core/nested_tag_capacity_checker.sv @@
// ----------------------------------------------------------------------------
// nested_tag_capacity_checker: stack-based nesting check with capacity rule
// Accepts one signed token per transfer and gives a pass/fail verdict after
// the token flagged as last.
// ----------------------------------------------------------------------------
// Throughput: one token per clock cycle, with no bubbles unless the verdict channel stalls.
// Latency: the verdict is valid on the cycle after the last token's transfer.
// The rate is set by the row of stack cells, which shifts one place per token
// so that the top two levels are always in registers next to the control.
// Reset clears the stack pointer, the failure latch and the output valid flag;
// the stack cells are not cleared, since only entries below the pointer count.
// ----------------------------------------------------------------------------
module nested_tag_capacity_checker
    import ntcc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Token channel.
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [TOKEN_W-1:0] i_token_value,
    input  logic                      i_last_token,
    // Verdict channel.
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_verdict
);

    // A token transfer happens whenever the output register is empty or is
    // being drained in the same cycle, so a waiting verdict does not stop
    // the input unless the downstream side is stalled.
    logic       w_in_fire;
    logic       w_out_fire;
    logic       w_res_verdict;

    logic       r_out_valid;
    logic       n_out_valid;
    logic       r_out_verdict;
    logic       n_out_verdict;

    t_stack_cmd w_cmd;
    t_status    w_status;
    t_entry     w_entries [MAX_DEPTH];

    assign o_ready    = !r_out_valid || i_ready;
    assign w_in_fire  = i_valid && o_ready;
    assign w_out_fire = r_out_valid && i_ready;

    // Control: decodes the token against the top two levels and decides
    // whether the cell row pushes, pops or holds.
    ntcc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_in_fire),
        .i_token_value (i_token_value),
        .i_last_token  (i_last_token),
        .i_top         (w_entries[0]),
        .i_next        (w_entries[1]),
        .o_cmd         (w_cmd),
        .o_status      (w_status),
        .o_verdict     (w_res_verdict)
    );

    // The stack as a row of cells. Cell 0 is the top. A push moves every
    // entry one cell down and loads the new level into cell 0; a pop moves
    // every entry one cell up, and cell 0 receives the parent with the
    // closed level's size already added to its inner sum.
    for (genvar g = 0; g < MAX_DEPTH; g++) begin : g_cell
        t_entry w_above;
        t_entry w_below;

        if (g == 0) begin : g_top
            assign w_above = w_cmd.push_entry;
            assign w_below = w_cmd.pop_entry;
        end else if (g == MAX_DEPTH - 1) begin : g_bottom
            assign w_above = w_entries[g-1];
            assign w_below = w_entries[g];
        end else begin : g_mid
            assign w_above = w_entries[g-1];
            assign w_below = w_entries[g+1];
        end

        ntcc_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (w_cmd.op),
            .i_above (w_above),
            .i_below (w_below),
            .o_entry (w_entries[g])
        );
    end

    // Output register. A verdict is produced only for the last token.
    always_comb begin
        n_out_valid   = r_out_valid;
        n_out_verdict = r_out_verdict;
        if (w_out_fire) begin
            n_out_valid = 1'b0;
        end
        if (w_in_fire && i_last_token) begin
            n_out_valid   = 1'b1;
            n_out_verdict = w_res_verdict;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_out_verdict <= n_out_verdict;
    end

    assign o_valid   = r_out_valid;
    assign o_verdict = r_out_verdict;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // The stack pointer never goes past the number of cells.
    a_sp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.sp <= SP_W'(MAX_DEPTH))
        else $error("stack pointer beyond stack depth");

    // The last token always leaves the checker rearmed.
    a_rearm_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_last_token) |=> (w_status.sp == '0) && !w_status.failed)
        else $error("checker not rearmed after last token");

    // Once failed, tokens inside the sequence leave the stack untouched.
    a_ignore_after_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && w_status.failed && !i_last_token) |=>
            (w_status.sp == $past(w_status.sp)) && w_status.failed)
        else $error("token processed after failure");

    // A failed sequence can never report a pass.
    a_fail_no_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_last_token && w_status.failed) |=> !o_verdict)
        else $error("pass reported for a failed sequence");

endmodule : nested_tag_capacity_checker
